@@ hdl/srsc_pkg.sv @@
// Package for the selective-repeat sender control block.
// Holds shared constants, packet codes, phase and state types and the
// command and status structs between controller and datapath. No dependencies.
package srsc_pkg;

    localparam int DEF_SLOTS       = 8;
    localparam int DEF_MAX_PACKETS = 4096;
    localparam int BYE_REPEATS     = 10;
    localparam int OUT_LIMIT       = 10;

    // Fixed field widths.
    localparam int NW  = 13;  // packet count and data sequence
    localparam int TW  = 16;  // timers and timeout
    localparam int SQW = 12;  // received ack sequence
    localparam int CNW = 4;   // results per item

    localparam logic [TW-1:0] RESET_TIMEOUT = 16'd1000;
    localparam logic [3:0]    RESET_WINDOW  = 4'd8;
    localparam logic [NW-1:0] RESET_COUNT   = 13'd1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_COUNT   = 2'd2;

    // Input operation and packet kinds.
    localparam logic       OP_TICK   = 1'b0;
    localparam logic       OP_PACKET = 1'b1;
    localparam logic [1:0] PK_REPLY  = 2'd0;
    localparam logic [1:0] PK_ACK    = 2'd1;

    // Send kinds.
    localparam logic [1:0] SK_INIT = 2'd0;
    localparam logic [1:0] SK_DATA = 2'd1;
    localparam logic [1:0] SK_BYE  = 2'd2;

    // Per-sequence status codes.
    localparam logic [1:0] ST_FRESH = 2'd0;
    localparam logic [1:0] ST_OUT   = 2'd1;
    localparam logic [1:0] ST_ACKED = 2'd2;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_DATA,
        PH_BYE
    } t_phase;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_INIT_TICK,
        S_INIT_WR,
        S_TICK,
        S_ACK_RD,
        S_ACK_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_BYE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic init_tick;
        logic init_load;
        logic init_wr;
        logic tick_slot;
        logic ack_rd;
        logic ack_mark;
        logic scan_rd;
        logic scan_adv;
        logic refill;
        logic bye_start;
        logic bye_emit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic   clr_done;
        t_phase phase;
        logic   op;
        logic   [1:0] kind;
        logic   seq_ok;
        logic   rd_acked;
        logic   rd_fresh;
        logic   ptr_end;
        logic   complete;
        logic   init_end;
        logic   tick_end;
        logic   bye_end;
        logic   emit_ok;
        logic   pend;
    } t_sts;

endpackage

@@ hdl/selective_repeat_sender_control.sv @@
// Sender side of a windowed selective-repeat transfer: after reset the block
// clears all MAX_PACKETS entries of its per-sequence status RAM and takes
// no item meanwhile (configuration writes are taken). Then a tick in the
// data phase walks the SLOTS timer slots one per cycle while the result
// buffer has room; an ack reads its status entry and, unless it is already
// acked, marks it and scans the status RAM from the lowest possibly-unsent
// sequence, reading and then checking each entry visited; that pointer only
// moves upward, so the scan cost is spread over the transfer. Result items
// leave through an output register one per cycle while the sink is ready;
// a waiting sink stalls the block.
// Depends on srsc_pkg, srsc_controller and srsc_datapath.
module selective_repeat_sender_control
    import srsc_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int MAX_PACKETS = DEF_MAX_PACKETS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [TW-1:0]  i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_operation,
    input  logic [1:0]     i_packet_kind,
    input  logic [SQW-1:0] i_ack_sequence,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_send_kind,
    output logic [NW-1:0]  o_send_sequence,
    output logic           o_last_of_run
);

    t_cmd w_cmd;
    t_sts w_sts;

    // The controller sequences each item; the datapath holds all other state.
    srsc_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    srsc_datapath #(
        .SLOTS       (SLOTS),
        .MAX_PACKETS (MAX_PACKETS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_packet_kind   (i_packet_kind),
        .i_ack_sequence  (i_ack_sequence),
        .i_out_ready     (i_out_ready),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .o_send_kind     (o_send_kind),
        .o_send_sequence (o_send_sequence),
        .o_last_of_run   (o_last_of_run)
    );

`ifndef SYNTHESIS
    // No item is taken before the status RAM has been cleared.
    a_accept_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> w_sts.clr_done)
        else $error("item accepted during status clear");

    // Between items no result is left waiting in the pending buffer.
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_sts.pend)
        else $error("pending result left behind at idle");

    // No slot step, bye result or finish runs while a result could be lost.
    a_tick_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.tick_slot || w_cmd.bye_emit || w_cmd.finish) |-> w_sts.emit_ok)
        else $error("result produced without room");
`endif

endmodule

@@ hdl/srsc_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module srsc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

@@ hdl/srsc_datapath.sv @@
// Datapath of the selective-repeat sender: configuration, slots, timers,
// sequence status RAM, fresh pointer and the result buffers.
// Depends on srsc_pkg and srsc_ram.
module srsc_datapath
    import srsc_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int MAX_PACKETS = DEF_MAX_PACKETS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [TW-1:0]  i_cfg_data,
    input  logic           i_operation,
    input  logic [1:0]     i_packet_kind,
    input  logic [SQW-1:0] i_ack_sequence,
    input  logic           i_out_ready,
    input  t_cmd           i_cmd,
    output t_sts           o_sts,
    output logic           o_out_valid,
    output logic [1:0]     o_send_kind,
    output logic [NW-1:0]  o_send_sequence,
    output logic           o_last_of_run
);

    localparam int AW  = $clog2(MAX_PACKETS);
    localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCW = $clog2(SLOTS + 1);

    logic [3:0]      r_win;
    logic [TW-1:0]   r_tmo;
    logic [NW-1:0]   r_pc;
    t_phase          r_phase;
    logic [TW-1:0]   r_init_tmr;
    logic            r_act  [SLOTS];
    logic [NW-1:0]   r_sseq [SLOTS];
    logic [TW-1:0]   r_stmr [SLOTS];
    logic [NW-1:0]   r_ptr;
    logic [NW-1:0]   r_acked;
    logic            r_clr_done;
    logic [AW-1:0]   r_clr_addr;
    logic            r_op;
    logic [1:0]      r_kind;
    logic [SQW-1:0]  r_seq;
    logic [CNW-1:0]  r_cnt;
    logic [SCW-1:0]  r_idx;
    logic            r_hit;
    logic [SIW-1:0]  r_hit_idx;
    logic            r_pend_v;
    logic [1:0]      r_pend_kind;
    logic [NW-1:0]   r_pend_seq;

    logic [NW-1:0]   w_n;
    logic [SCW-1:0]  w_w;
    logic [SCW-1:0]  w_load;
    logic [TW-1:0]   w_reload;
    logic            w_found;
    logic [SIW-1:0]  w_found_idx;
    logic [SIW-1:0]  w_ti;
    logic            w_emit;
    logic [1:0]      w_ekind;
    logic [NW-1:0]   w_eseq;
    logic            w_out_free;
    logic            w_we;
    logic [AW-1:0]   w_addr;
    logic [1:0]      w_wdata;
    logic [1:0]      w_rdata;

    always_comb begin
        if (r_pc == '0) begin
            w_n = NW'(1);
        end else if (int'(r_pc) > MAX_PACKETS) begin
            w_n = NW'(MAX_PACKETS);
        end else begin
            w_n = r_pc;
        end
        if (r_win == '0) begin
            w_w = SCW'(1);
        end else if (int'(r_win) > SLOTS) begin
            w_w = SCW'(SLOTS);
        end else begin
            w_w = SCW'(r_win);
        end
        w_load   = (int'(w_w) < int'(w_n)) ? w_w : SCW'(w_n);
        w_reload = (r_tmo == '0) ? TW'(1) : r_tmo;
    end

    // Slot holding the acked sequence, lowest index first.
    always_comb begin
        w_found     = 1'b0;
        w_found_idx = '0;
        for (int j = 0; j < SLOTS; j++) begin
            if (!w_found && r_act[j] && r_sseq[j] == NW'(r_seq)) begin
                w_found     = 1'b1;
                w_found_idx = SIW'(j);
            end
        end
    end

    assign w_ti = r_idx[SIW-1:0];

    always_comb begin
        w_emit  = 1'b0;
        w_ekind = SK_INIT;
        w_eseq  = w_n;
        if (i_cmd.init_tick && r_init_tmr <= TW'(1)) begin
            w_emit = 1'b1;
        end
        if (i_cmd.tick_slot && r_act[w_ti] && r_stmr[w_ti] <= TW'(1)
            && int'(r_cnt) < OUT_LIMIT) begin
            w_emit  = 1'b1;
            w_ekind = SK_DATA;
            w_eseq  = r_sseq[w_ti];
        end
        if (i_cmd.bye_emit) begin
            w_emit  = 1'b1;
            w_ekind = SK_BYE;
        end
    end

    assign w_out_free = !o_out_valid || i_out_ready;

    always_comb begin
        w_we    = 1'b0;
        w_addr  = AW'(r_seq);
        w_wdata = ST_FRESH;
        priority if (i_cmd.clr_step) begin
            w_we   = 1'b1;
            w_addr = r_clr_addr;
        end else if (i_cmd.init_wr) begin
            w_we    = 1'b1;
            w_addr  = AW'(r_idx);
            w_wdata = ST_OUT;
        end else if (i_cmd.ack_mark) begin
            w_we    = 1'b1;
            w_wdata = ST_ACKED;
        end else if (i_cmd.refill || i_cmd.scan_rd) begin
            w_we    = i_cmd.refill && r_hit;
            w_addr  = AW'(r_ptr);
            w_wdata = ST_OUT;
        end else begin
            w_we = 1'b0;
        end
    end

    srsc_ram #(
        .WIDTH (2),
        .DEPTH (MAX_PACKETS)
    ) u_status (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= RESET_WINDOW;
            r_tmo       <= RESET_TIMEOUT;
            r_pc        <= RESET_COUNT;
            r_phase     <= PH_INIT;
            r_init_tmr  <= RESET_TIMEOUT;
            r_ptr       <= '0;
            r_acked     <= '0;
            r_clr_done  <= 1'b0;
            r_clr_addr  <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_pend_v    <= 1'b0;
            o_out_valid <= 1'b0;
            for (int j = 0; j < SLOTS; j++) begin
                r_act[j] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WINDOW:  r_win <= i_cfg_data[3:0];
                    CFG_TIMEOUT: r_tmo <= i_cfg_data;
                    CFG_COUNT:   r_pc  <= i_cfg_data[NW-1:0];
                    default:     ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.clr_step) begin
                if (r_clr_addr == AW'(MAX_PACKETS - 1)) begin
                    r_clr_done <= 1'b1;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
            if (i_cmd.accept) begin
                r_op   <= i_operation;
                r_kind <= i_packet_kind;
                r_seq  <= i_ack_sequence;
                r_cnt  <= '0;
                r_idx  <= '0;
            end
            if (i_cmd.init_tick) begin
                if (r_init_tmr <= TW'(1)) begin
                    r_init_tmr <= w_reload;
                end else begin
                    r_init_tmr <= r_init_tmr - TW'(1);
                end
            end
            if (i_cmd.init_load) begin
                r_phase <= PH_DATA;
                r_ptr   <= NW'(w_load);
                for (int j = 0; j < SLOTS; j++) begin
                    if (j < int'(w_load)) begin
                        r_act[j]  <= 1'b1;
                        r_sseq[j] <= NW'(j);
                        r_stmr[j] <= '0;
                    end
                end
            end
            if (i_cmd.init_wr) begin
                r_idx <= r_idx + SCW'(1);
            end
            if (i_cmd.tick_slot) begin
                r_idx <= r_idx + SCW'(1);
                if (r_act[w_ti]) begin
                    if (r_stmr[w_ti] <= TW'(1)) begin
                        if (int'(r_cnt) < OUT_LIMIT) begin
                            r_stmr[w_ti] <= w_reload;
                            r_cnt        <= r_cnt + CNW'(1);
                        end
                    end else begin
                        r_stmr[w_ti] <= r_stmr[w_ti] - TW'(1);
                    end
                end
            end
            if (i_cmd.ack_mark) begin
                r_acked   <= r_acked + NW'(1);
                r_hit     <= w_found;
                r_hit_idx <= w_found_idx;
                if (w_found) begin
                    r_act[w_found_idx] <= 1'b0;
                end
            end
            if (i_cmd.scan_adv) begin
                r_ptr <= r_ptr + NW'(1);
            end
            if (i_cmd.refill && r_hit) begin
                r_act[r_hit_idx]  <= 1'b1;
                r_sseq[r_hit_idx] <= r_ptr;
                r_stmr[r_hit_idx] <= '0;
            end
            if (i_cmd.bye_start) begin
                r_phase <= PH_BYE;
            end
            if (i_cmd.bye_emit) begin
                r_cnt <= r_cnt + CNW'(1);
            end
            // A new result waits in the pending buffer until the next one
            // or the end of the item tells whether it is the last.
            if (w_emit) begin
                r_pend_v    <= 1'b1;
                r_pend_kind <= w_ekind;
                r_pend_seq  <= w_eseq;
            end
            if ((w_emit || i_cmd.finish) && r_pend_v) begin
                o_out_valid     <= 1'b1;
                o_send_kind     <= r_pend_kind;
                o_send_sequence <= r_pend_seq;
                o_last_of_run   <= i_cmd.finish;
                if (i_cmd.finish) begin
                    r_pend_v <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_sts.clr_done = r_clr_done;
        o_sts.phase    = r_phase;
        o_sts.op       = r_op;
        o_sts.kind     = r_kind;
        o_sts.seq_ok   = NW'(r_seq) < w_n;
        o_sts.rd_acked = w_rdata == ST_ACKED;
        o_sts.rd_fresh = w_rdata == ST_FRESH;
        o_sts.ptr_end  = r_ptr >= w_n;
        o_sts.complete = r_acked >= w_n;
        o_sts.init_end = r_idx >= w_load;
        o_sts.tick_end = int'(r_idx) >= SLOTS;
        o_sts.bye_end  = int'(r_cnt) >= BYE_REPEATS;
        o_sts.emit_ok  = !r_pend_v || w_out_free;
        o_sts.pend     = r_pend_v;
    end

endmodule

@@ hdl/srsc_controller.sv @@
// Controller state machine of the selective-repeat sender.
// Depends on srsc_pkg; drives the datapath by command struct.
module srsc_controller
    import srsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                priority if (i_sts.phase == PH_BYE) begin
                    n_state = S_FINISH;
                end else if (i_sts.op == OP_TICK) begin
                    n_state = (i_sts.phase == PH_INIT) ? S_INIT_TICK : S_TICK;
                end else if (i_sts.phase == PH_INIT) begin
                    n_state = (i_sts.kind == PK_REPLY) ? S_INIT_WR : S_FINISH;
                end else if (i_sts.kind == PK_ACK && i_sts.seq_ok) begin
                    n_state = S_ACK_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_INIT_TICK: begin
                if (i_sts.emit_ok) n_state = S_FINISH;
            end
            S_INIT_WR: begin
                if (i_sts.init_end) n_state = S_FINISH;
            end
            S_TICK: begin
                if (i_sts.tick_end) n_state = S_FINISH;
            end
            S_ACK_RD: n_state = S_ACK_CHK;
            S_ACK_CHK: begin
                n_state = i_sts.rd_acked ? S_FINISH : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (i_sts.ptr_end) begin
                    n_state = i_sts.complete ? S_BYE : S_FINISH;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                n_state = i_sts.rd_fresh ? S_FINISH : S_SCAN_RD;
            end
            S_BYE: begin
                if (i_sts.bye_end) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.emit_ok) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = !i_sts.clr_done;
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_DISPATCH: begin
                o_cmd.init_load = i_sts.phase == PH_INIT && i_sts.op == OP_PACKET
                                  && i_sts.kind == PK_REPLY;
            end
            S_INIT_TICK: o_cmd.init_tick = i_sts.emit_ok;
            S_INIT_WR:   o_cmd.init_wr   = !i_sts.init_end;
            S_TICK:      o_cmd.tick_slot = !i_sts.tick_end && i_sts.emit_ok;
            S_ACK_RD:    o_cmd.ack_rd    = 1'b1;
            S_ACK_CHK:   o_cmd.ack_mark  = !i_sts.rd_acked;
            S_SCAN_RD: begin
                o_cmd.scan_rd   = !i_sts.ptr_end;
                o_cmd.bye_start = i_sts.ptr_end && i_sts.complete;
            end
            S_SCAN_CHK: begin
                o_cmd.refill   = i_sts.rd_fresh;
                o_cmd.scan_adv = !i_sts.rd_fresh;
            end
            S_BYE:    o_cmd.bye_emit = !i_sts.bye_end && i_sts.emit_ok;
            S_FINISH: o_cmd.finish   = i_sts.emit_ok;
            default:  o_cmd = '0;
        endcase
    end

endmodule
